FILE: sv/scms_pkg.sv
// Package for the sliding-window count-min sketch.
// Holds shared sizes and constants; depends on nothing.
package scms_pkg;
    localparam int ROWS_DEF = 4;
    localparam int BUCKETS_DEF = 1024;
    localparam int FIELDS_DEF = 2;
    localparam int IDX_W = 10;
    localparam logic [31:0] RATE_RESET = 32'h0001_0000;
    localparam logic [30:0] EST_MAX = 31'h7fff_ffff;
    localparam logic [31:0] CNT_MAX = 32'hffff_ffff;
    localparam int COUNT_W = 48;
endpackage

FILE: sv/scms_lane.sv
// One row of the sketch: a bank holding that row's buckets.
// Depends on scms_pkg. Clears, increments and reads field sums.
module scms_lane #(
    parameter int BUCKETS = scms_pkg::BUCKETS_DEF,
    parameter int FIELDS = scms_pkg::FIELDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_clr_we,
    input  logic [$clog2(BUCKETS)-1:0]   i_clr_addr,
    input  logic [$clog2(FIELDS)-1:0]    i_clr_field,
    input  logic                         i_rd,
    input  logic [$clog2(BUCKETS)-1:0]   i_addr,
    input  logic                         i_inc_we,
    input  logic [$clog2(FIELDS)-1:0]    i_inc_field,
    output logic [31+$clog2(FIELDS)+1:0] o_sum
);
    import scms_pkg::*;
    localparam int AW = $clog2(BUCKETS);
    localparam int FW = $clog2(FIELDS);
    localparam int SW = 32 + FW + 1;

    logic [31:0] mem [FIELDS][BUCKETS];
    logic [31:0] r_rd [FIELDS];
    logic [AW-1:0] r_addr;

    // One field bank per counter field; each has one write and one read port.
    for (genvar f = 0; f < FIELDS; f++) begin : g_f
        always_ff @(posedge i_clk) begin
            if (i_rd) begin
                r_rd[f] <= mem[f][i_addr];
            end
            if (i_clr_we && i_clr_field == FW'(f)) begin
                mem[f][i_clr_addr] <= '0;
            end else if (i_inc_we && i_inc_field == FW'(f) && r_rd[f] != CNT_MAX) begin
                mem[f][r_addr] <= r_rd[f] + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_addr <= i_addr;
        end
    end

    // Sum of the bucket's fields at full width.
    always_comb begin
        o_sum = '0;
        for (int f = 0; f < FIELDS; f++) begin
            o_sum = o_sum + SW'(r_rd[f]);
        end
    end
endmodule

FILE: sv/scms_min.sv
// Merging stage: minimum over the row sums, saturated to the estimate range.
// Depends on scms_pkg.
module scms_min #(
    parameter int ROWS = scms_pkg::ROWS_DEF,
    parameter int SW = 34
) (
    input  logic [SW-1:0] i_sum [ROWS],
    output logic [30:0]   o_est
);
    import scms_pkg::*;
    logic [SW-1:0] best;

    // Linear minimum over the rows, starting from the saturation value.
    always_comb begin
        best = SW'(EST_MAX);
        for (int r = 0; r < ROWS; r++) begin
            if (i_sum[r] < best) begin
                best = i_sum[r];
            end
        end
        o_est = best[30:0];
    end
endmodule

FILE: sv/sliding_count_min_sketch_unit.sv
// Sliding-window count-min sketch top level.
// Depends on scms_pkg, scms_lane and scms_min.
//
// Usage: raise start with i_command, i_timestamp and the row indices while
// busy is low; the request is taken at that edge. A query (command 1)
// gives o_estimate with o_valid high for one cycle; an insert gives nothing.
// The receiver cannot stall; results are shown for exactly one cycle.
// A query runs ST_RD, ST_WAIT and ST_QOUT and strobes as busy goes low, so
// the next request can be taken while the strobe is shown. An insert with no
// clearing owed forms the rate product in ST_MUL1 and ST_MUL2, the lag in
// ST_LAG and the read-modify-write in ST_RD, ST_WAIT and ST_INC. Each clearing
// step owed is one pass through ST_STEP, plus one to leave the walk. A lag of
// at least ROWS*BUCKETS*FIELDS steps is first reduced in ST_MOD by compare and
// subtract, one shifted multiple per residue bit, then a full clear, then the
// residue steps. After reset the block sweeps the whole store with busy high.
// Write i_cfg_we only while busy is low; it sets the clearing rate.
module sliding_count_min_sketch_unit #(
    parameter int ROWS = scms_pkg::ROWS_DEF,
    parameter int BUCKETS_PER_ROW = scms_pkg::BUCKETS_DEF,
    parameter int FIELDS = scms_pkg::FIELDS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [31:0]              i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_command,
    input  logic [31:0]              i_timestamp,
    input  logic [scms_pkg::IDX_W-1:0] i_row_index_0,
    input  logic [scms_pkg::IDX_W-1:0] i_row_index_1,
    input  logic [scms_pkg::IDX_W-1:0] i_row_index_2,
    input  logic [scms_pkg::IDX_W-1:0] i_row_index_3,
    output logic                     o_valid,
    output logic [30:0]              o_estimate
);
    import scms_pkg::*;
    localparam int AW = $clog2(BUCKETS_PER_ROW);
    localparam int FW = $clog2(FIELDS);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW = 32 + FW + 1;
    localparam longint CELLS = longint'(ROWS) * BUCKETS_PER_ROW * FIELDS;
    localparam int CLW = $clog2(CELLS + 1);
    localparam int KMAX = COUNT_W - CLW;
    localparam int KW = $clog2(KMAX + 1);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_MUL1, ST_MUL2, ST_LAG, ST_MOD, ST_FULL,
        ST_STEP, ST_RD, ST_WAIT, ST_INC, ST_QWAIT, ST_QOUT
    } t_state;

    t_state r_state;
    logic [31:0] r_rate;
    logic r_cmd;
    logic [31:0] r_ts;
    logic [AW-1:0] r_idx [ROWS];
    logic [47:0] r_prod;
    logic [COUNT_W-1:0] r_count, r_target, r_lag;
    logic [KW-1:0] r_shift;
    logic [AW-1:0] r_scan_b;
    logic [RW-1:0] r_scan_r;
    logic [FW-1:0] r_win;
    logic [AW-1:0] r_sweep;
    logic [FW-1:0] r_fsel;
    logic r_out_v;
    logic [30:0] r_est;

    logic [AW-1:0] in_idx [4];
    logic lane_rd, lane_inc;
    logic lane_clr [ROWS];
    logic [AW-1:0] clr_addr;
    logic [FW-1:0] clr_field;
    logic [FW-1:0] inc_field [ROWS];
    logic [SW-1:0] sums [ROWS];
    logic [30:0] est;
    logic [FW-1:0] win_next;
    logic [COUNT_W-1:0] lag_now;
    logic [63:0] cells_shl;

    // Index reduced modulo the row size by constant compare and subtract.
    function automatic logic [AW-1:0] reduce_index(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        v = 32'(idx);
        for (int k = 6; k >= 0; k--) begin
            if (v >= (32'(BUCKETS_PER_ROW) << k)) begin
                v = v - (32'(BUCKETS_PER_ROW) << k);
            end
        end
        return AW'(v);
    endfunction

    assign in_idx[0] = reduce_index(i_row_index_0);
    assign in_idx[1] = reduce_index(i_row_index_1);
    assign in_idx[2] = reduce_index(i_row_index_2);
    assign in_idx[3] = reduce_index(i_row_index_3);
    assign win_next = (r_win == FW'(FIELDS - 1)) ? '0 : r_win + FW'(1);
    assign lag_now = r_target - r_count;
    assign cells_shl = 64'(CELLS) << r_shift;

    // Lane control: a sweep or full clear clears all fields, a step clears one field of one bucket.
    always_comb begin
        lane_rd = (r_state == ST_RD);
        lane_inc = (r_state == ST_INC) && !r_cmd;
        clr_addr = (r_state == ST_STEP) ? r_scan_b : r_sweep;
        clr_field = win_next;
        for (int r = 0; r < ROWS; r++) begin
            lane_clr[r] = (r_state == ST_SWEEP) || (r_state == ST_FULL) ||
                ((r_state == ST_STEP) && (r_lag != '0) && r_scan_r == RW'(r));
            // Bucket already passed by the scan uses the next field.
            if (RW'(r) < r_scan_r || (RW'(r) == r_scan_r && r_idx[r] < r_scan_b)) begin
                inc_field[r] = win_next;
            end else begin
                inc_field[r] = r_win;
            end
        end
    end

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        logic [FW-1:0] cf;
        logic sweep_all;
        assign sweep_all = (r_state == ST_SWEEP) || (r_state == ST_FULL);
        scms_lane #(.BUCKETS(BUCKETS_PER_ROW), .FIELDS(FIELDS)) u_lane (
            .i_clk      (i_clk),
            .i_clr_we   (lane_clr[r]),
            .i_clr_addr (clr_addr),
            .i_clr_field(cf),
            .i_rd       (lane_rd),
            .i_addr     (r_idx[r]),
            .i_inc_we   (lane_inc),
            .i_inc_field(inc_field[r]),
            .o_sum      (sums[r])
        );
        // Full clears walk every field through the field counter.
        assign cf = sweep_all ? r_fsel : clr_field;
    end

    scms_min #(.ROWS(ROWS), .SW(SW)) u_min (
        .i_sum(sums),
        .o_est(est)
    );

    assign busy = (r_state != ST_IDLE);
    assign o_valid = r_out_v;
    assign o_estimate = r_est;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_wdata;
        end
    end

    // Sequencer: clearing walk, lane accesses and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_sweep <= '0;
            r_fsel <= '0;
            r_count <= '0;
            r_scan_b <= '0;
            r_scan_r <= '0;
            r_win <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            unique case (r_state)
                ST_SWEEP, ST_FULL: begin
                    if (r_fsel == FW'(FIELDS - 1)) begin
                        r_fsel <= '0;
                        r_sweep <= r_sweep + AW'(1);
                        if (r_sweep == AW'(BUCKETS_PER_ROW - 1)) begin
                            r_state <= (r_state == ST_SWEEP) ? ST_IDLE : ST_STEP;
                        end
                    end else begin
                        r_fsel <= r_fsel + FW'(1);
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_cmd <= i_command;
                        r_ts <= i_timestamp;
                        for (int r = 0; r < ROWS; r++) begin
                            r_idx[r] <= in_idx[r % 4];
                        end
                        r_state <= i_command ? ST_RD : ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    // Low half of the rate times the timestamp.
                    r_prod <= 48'(r_ts) * 48'(r_rate[15:0]);
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_target <= COUNT_W'(r_ts) * COUNT_W'(r_rate[31:16])
                        + COUNT_W'(r_prod[47:16]);
                    r_state <= ST_LAG;
                end
                ST_LAG: begin
                    if (r_target <= r_count) begin
                        r_state <= ST_RD;
                    end else begin
                        r_lag <= lag_now;
                        r_count <= r_target;
                        r_shift <= KW'(KMAX);
                        r_sweep <= '0;
                        r_fsel <= '0;
                        r_state <= (lag_now >= COUNT_W'(CELLS)) ? ST_MOD : ST_STEP;
                    end
                end
                ST_MOD: begin
                    // Residue of a long lag, one shifted multiple a cycle.
                    if (64'(r_lag) >= cells_shl) begin
                        r_lag <= r_lag - COUNT_W'(cells_shl);
                    end
                    if (r_shift == '0) begin
                        r_state <= ST_FULL;
                    end else begin
                        r_shift <= r_shift - KW'(1);
                    end
                end
                ST_STEP: begin
                    if (r_lag == '0) begin
                        r_state <= ST_RD;
                    end else begin
                        r_lag <= r_lag - COUNT_W'(1);
                        if (r_scan_b == AW'(BUCKETS_PER_ROW - 1)) begin
                            r_scan_b <= '0;
                            if (r_scan_r == RW'(ROWS - 1)) begin
                                r_scan_r <= '0;
                                r_win <= win_next;
                            end else begin
                                r_scan_r <= r_scan_r + RW'(1);
                            end
                        end else begin
                            r_scan_b <= r_scan_b + AW'(1);
                        end
                    end
                end
                ST_RD: r_state <= ST_WAIT;
                ST_WAIT: r_state <= r_cmd ? ST_QOUT : ST_INC;
                ST_INC: r_state <= ST_IDLE;
                ST_QOUT: begin
                    r_out_v <= 1'b1;
                    r_est <= est;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/scms_tb_pkg.sv
`timescale 1ns / 100ps
// Request codes shared by the sketch testbench and its checker.
// Depends on nothing.
package scms_tb_pkg;
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } sketch_cmd_e;
endpackage

FILE: tb/scms_checker.sv
`timescale 1ns / 100ps
// Checker for the sliding count-min sketch: mirrors the store and compares estimates.
// Depends on scms_pkg and scms_tb_pkg.
module scms_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_command,
    input  logic [31:0] i_timestamp,
    input  logic [9:0]  i_row_index_0,
    input  logic [9:0]  i_row_index_1,
    input  logic [9:0]  i_row_index_2,
    input  logic [9:0]  i_row_index_3,
    input  logic        i_valid,
    input  logic [30:0] i_estimate,
    output int          o_fail_count,
    output int          o_pending
);
    import scms_pkg::*;
    import scms_tb_pkg::*;

    localparam int NROWS   = ROWS_DEF;
    localparam int NBKT    = BUCKETS_DEF;
    localparam int NFLD    = FIELDS_DEF;
    localparam int NBUCKET = NROWS * NBKT;
    localparam int NCELL   = NBUCKET * NFLD;

    logic [31:0] cells [NCELL];
    int          scan_pos;
    int          win_field;
    logic [47:0] steps_done;
    logic [31:0] rate;
    logic [30:0] estimates_due [$];

    // Zeroes the trailing field of the bucket under the scan pointer and moves on.
    task automatic clear_step();
        cells[scan_pos * NFLD + (win_field + 1) % NFLD] = '0;
        scan_pos = (scan_pos + 1) % NBUCKET;
        if (scan_pos == 0) win_field = (win_field + 1) % NFLD;
    endtask

    // Runs the clearing walk up to the step count that the timestamp calls for.
    task automatic catch_up(input logic [31:0] ts);
        logic [63:0] prod;
        logic [47:0] target;
        logic [47:0] lag;
        prod   = {32'b0, ts} * {32'b0, rate};
        target = prod[63:16];
        if (target > steps_done) begin
            lag = target - steps_done;
            if (lag >= NCELL) begin
                foreach (cells[i]) cells[i] = '0;
                lag = lag % NCELL;
            end
            while (lag > 0) begin
                clear_step();
                lag--;
            end
            steps_done = target;
        end
    endtask

    function automatic int bucket_at(input int row, input logic [9:0] idx [4]);
        return int'(idx[row % 4]) % NBKT + row * NBKT;
    endfunction

    // Applies one accepted request to the mirrored store.
    task automatic apply_request();
        logic [9:0]  idx [4];
        logic [63:0] best;
        logic [63:0] sum;
        int          pos;
        idx = '{i_row_index_0, i_row_index_1, i_row_index_2, i_row_index_3};
        if (sketch_cmd_e'(i_command) == CMD_INSERT) begin
            catch_up(i_timestamp);
            for (int r = 0; r < NROWS; r++) begin
                pos = bucket_at(r, idx);
                pos = pos * NFLD + (win_field + (pos < scan_pos ? 1 : 0)) % NFLD;
                if (cells[pos] != CNT_MAX) cells[pos] = cells[pos] + 1;
            end
        end else begin
            best = 64'(EST_MAX);
            for (int r = 0; r < NROWS; r++) begin
                pos = bucket_at(r, idx);
                sum = '0;
                for (int f = 0; f < NFLD; f++) sum += cells[pos * NFLD + f];
                if (sum < best) best = sum;
            end
            estimates_due.push_back(best[30:0]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (cells[i]) cells[i] = '0;
            scan_pos     = 0;
            win_field    = 0;
            steps_done   = '0;
            rate         = RATE_RESET;
            o_fail_count = 0;
            estimates_due.delete();
        end else begin
            if (i_cfg_we) rate = i_cfg_wdata;
            if (i_valid) begin
                if (estimates_due.size() == 0) begin
                    $error("estimate %0h arrived with no query outstanding", i_estimate);
                    o_fail_count++;
                end else begin
                    if (i_estimate !== estimates_due[0]) begin
                        $error("estimate: expected %0h, actual %0h",
                               estimates_due[0], i_estimate);
                        o_fail_count++;
                    end
                    void'(estimates_due.pop_front());
                end
            end
            if (i_start && !i_busy) apply_request();
        end
        o_pending = estimates_due.size();
    end
endmodule

FILE: tb/tb_sliding_count_min_sketch_unit.sv
`timescale 1ns / 100ps
// Top of the sketch testbench: clock, reset, request stimulus and verdict.
// Depends on scms_pkg, scms_tb_pkg, scms_checker and the sketch unit.
module tb_sliding_count_min_sketch_unit;
    import scms_pkg::*;
    import scms_tb_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = 1'b0;
    logic [31:0] i_timestamp = '0;
    logic [9:0]  i_row_index_0 = '0;
    logic [9:0]  i_row_index_1 = '0;
    logic [9:0]  i_row_index_2 = '0;
    logic [9:0]  i_row_index_3 = '0;
    logic        o_valid;
    logic [30:0] o_estimate;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic [31:0] now_ts = '0;
    logic [9:0]  key_pool [8][4];

    always #2 i_clk = ~i_clk;

    sliding_count_min_sketch_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy), .i_command(i_command), .i_timestamp(i_timestamp),
        .i_row_index_0(i_row_index_0), .i_row_index_1(i_row_index_1),
        .i_row_index_2(i_row_index_2), .i_row_index_3(i_row_index_3),
        .o_valid(o_valid), .o_estimate(o_estimate)
    );

    scms_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(start), .i_busy(busy), .i_command(i_command), .i_timestamp(i_timestamp),
        .i_row_index_0(i_row_index_0), .i_row_index_1(i_row_index_1),
        .i_row_index_2(i_row_index_2), .i_row_index_3(i_row_index_3),
        .i_valid(o_valid), .i_estimate(o_estimate),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: ends the run when nothing has been accepted or returned for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request and waits until busy is low; start is left high.
    task automatic send(input sketch_cmd_e cmd, input logic [31:0] ts,
                        input logic [9:0] a, input logic [9:0] b,
                        input logic [9:0] c, input logic [9:0] d);
        start         <= 1'b1;
        i_command     <= cmd;
        i_timestamp   <= ts;
        i_row_index_0 <= a;
        i_row_index_1 <= b;
        i_row_index_2 <= c;
        i_row_index_3 <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Waits for every estimate and for the clearing walk to finish.
    task automatic drain();
        pause(1);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_rate(input logic [31:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic over a small key pool, in bursts, with time mostly moving forward.
    task automatic random_phase(input int items, input int max_delta);
        int          burst;
        int          k;
        logic [9:0]  idx [4];
        sketch_cmd_e cmd;
        burst = 0;
        for (int n = 0; n < items; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
            end
            burst--;
            if (n == items / 2) begin
                // Let the block empty completely once per phase.
                pause(1);
                while (pending != 0 || busy) @(posedge i_clk);
            end
            k = $urandom_range(0, 7);
            idx = key_pool[k];
            if ($urandom_range(0, 9) == 0)
                foreach (idx[r]) idx[r] = 10'($urandom);
            cmd = ($urandom_range(0, 2) == 0) ? CMD_QUERY : CMD_INSERT;
            case ($urandom_range(0, 99))
                0:       now_ts = $urandom;
                1:       now_ts = now_ts - $urandom_range(0, 50);
                2:       now_ts = now_ts + $urandom_range(8000, 12000);
                default: now_ts = now_ts + $urandom_range(0, max_delta);
            endcase
            send(cmd, (cmd == CMD_QUERY) ? $urandom : now_ts, idx[0], idx[1], idx[2], idx[3]);
        end
    endtask

    initial begin
        foreach (key_pool[k, r]) key_pool[k][r] = 10'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: index extremes, repeated keys, time going back, long lags.
        send(CMD_INSERT, 32'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send(CMD_INSERT, 32'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send(CMD_QUERY, 32'hffff_ffff, 10'd0, 10'd0, 10'd0, 10'd0);
        send(CMD_QUERY, 32'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send(CMD_QUERY, 32'd0, 10'd0, 10'd1023, 10'd0, 10'd1023);
        send(CMD_INSERT, 32'd900, 10'd5, 10'd6, 10'd7, 10'd8);
        send(CMD_INSERT, 32'd850, 10'd5, 10'd6, 10'd7, 10'd8);
        send(CMD_QUERY, 32'd0, 10'd5, 10'd6, 10'd7, 10'd8);
        send(CMD_INSERT, 32'd20000, 10'd3, 10'd3, 10'd3, 10'd3);
        send(CMD_QUERY, 32'd0, 10'd5, 10'd6, 10'd7, 10'd8);
        send(CMD_QUERY, 32'd0, 10'd3, 10'd3, 10'd3, 10'd3);
        send(CMD_INSERT, 32'hffff_ffff, 10'h2aa, 10'h155, 10'h2aa, 10'h155);
        send(CMD_QUERY, 32'd0, 10'h2aa, 10'h155, 10'h2aa, 10'h155);
        send(CMD_INSERT, 32'd7, 10'd9, 10'd9, 10'd9, 10'd9);
        send(CMD_QUERY, 32'd0, 10'd9, 10'd9, 10'd9, 10'd9);
        now_ts = 32'hffff_ffff;

        set_rate(32'd0);
        send(CMD_INSERT, 32'hffff_ffff, 10'd1, 10'd2, 10'd3, 10'd4);
        send(CMD_QUERY, 32'd0, 10'd1, 10'd2, 10'd3, 10'd4);

        // Random phases across clearing rates, the extremes among them.
        set_rate(32'h0001_0000);
        now_ts = '0;
        random_phase(480, 8);
        set_rate(32'd0);
        random_phase(300, 8);
        set_rate(32'hffff_ffff);
        random_phase(20, 1);
        set_rate(32'h0000_4000);
        random_phase(450, 16);
        set_rate(32'h0003_0000);
        random_phase(380, 8);

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
